@@ rtl/image_request_line_parser_defines.svh @@
// assertion macros shared by the checker
`ifndef IMAGE_REQUEST_LINE_PARSER_DEFINES_SVH
`define IMAGE_REQUEST_LINE_PARSER_DEFINES_SVH

// property that must hold at every edge outside reset
`define IRLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// property checked at every edge, reset included
`define IRLP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ rtl/irlp_pkg.sv @@
`default_nettype none
package irlp_pkg;

  typedef enum logic [3:0] {
    PH_PRE_METHOD, PH_METHOD, PH_PRE_TARGET, PH_CATEGORY, PH_ID, PH_SIZE,
    PH_EXT, PH_QUERY, PH_PRE_VERSION, PH_VERSION, PH_POST
  } phase_t;

  localparam logic [12:0] COUNT_MAX = 13'd8191;
  localparam logic [2:0]  CAT_CHAR  = 3'd2;
  localparam logic        REG_MAX_LINE  = 1'b0;
  localparam logic        REG_MAX_QUERY = 1'b1;

  // per-category name length
  function automatic logic [3:0] cat_len(input logic [2:0] i);
    case (i)
      3'd0: cat_len = 4'd8;
      3'd1: cat_len = 4'd11;
      3'd2: cat_len = 4'd9;
      3'd3: cat_len = 4'd13;
      3'd4: cat_len = 4'd6;
      default: cat_len = 4'd0;
    endcase
  endfunction

  // character of a category name at a position, 0 beyond the end
  function automatic logic [7:0] cat_char(input logic [2:0] i, input logic [3:0] p);
    logic [8*13-1:0] s;
    s = '0;
    case (i)
      3'd0: s = {"Alliance", 40'd0};
      3'd1: s = {"Corporation", 16'd0};
      3'd2: s = {"Character", 32'd0};
      3'd3: s = "InventoryType";
      3'd4: s = {"Render", 56'd0};
      default: s = '0;
    endcase
    if (p < 4'd13) cat_char = s[8*(12-p) +: 8];
    else cat_char = 8'd0;
  endfunction

endpackage
`default_nettype wire

@@ rtl/image_request_line_parser.sv @@
// image request line parser
// input channel: in_line_byte / in_line_end with in_valid / in_ready, one
// byte per item; in_line_end marks the last byte of a request line
// result channel: out_accepted, out_category_code, out_image_id,
// out_image_size with out_valid / out_ready; one item per line, issued for
// the last byte, all fields zero when the line is rejected
// configuration: cfg_we, cfg_index, cfg_data write the line length limit
// (index 0) and the query length limit (index 1)
// throughput: one byte per cycle while in_ready is high; the byte state is
// updated at the accept edge and the verdict for a last byte is registered
// in the same edge, so a result appears in the cycle after its last byte is
// taken
// stalls: the result register holds while out_ready is low; in_ready is low
// whenever a result waits and out_ready is low, for any byte
// reset: synchronous active low; line state cleared, limits back to 2048
// and 512, no result pending
`default_nettype none
module image_request_line_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_line_byte,
  input  wire logic        in_line_end,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_accepted,
  output logic [2:0]       out_category_code,
  output logic [31:0]      out_image_id,
  output logic [31:0]      out_image_size,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [11:0] cfg_data
);

  localparam logic [32:0] NUM_OVER = 33'h1_0000_0000;

  logic [11:0] max_line_r, max_query_r;
  irlp_pkg::phase_t ph_r, ph_nxt;
  logic [12:0] line_cnt_r, line_cnt_nxt, query_cnt_r, query_cnt_nxt;
  logic [3:0]  lit_pos_r, lit_pos_nxt;
  logic [4:0]  cand_r, cand_nxt;
  logic        rej_r, rej_nxt;
  logic [32:0] id_r, id_nxt, size_r, size_nxt;
  logic [1:0]  digits_r, digits_nxt;
  logic [2:0]  ext_pos_r, ext_pos_nxt;
  logic [1:0]  ext_m_r, ext_m_nxt;
  logic [2:0]  cat_r, cat_nxt;

  logic        take;
  logic        ws, is_dig;
  logic [7:0]  c;
  logic [32:0] num_in, num_out;
  logic [36:0] num_prod;
  logic        ok;
  logic        fin_path_bad;
  logic        mask_len_ok;
  logic [4:0]  cand_tmp;

  assign in_ready = !out_valid || out_ready;
  assign take = in_valid && in_ready;
  assign c = in_line_byte;
  assign ws = (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  assign is_dig = (c >= "0") && (c <= "9");

  // shared decimal accumulator: only id or size grows in one byte
  assign num_in = (ph_r == irlp_pkg::PH_SIZE) ? size_r : id_r;
  assign num_prod = {4'd0, num_in} * 37'd10 + {29'd0, c - 8'd48};
  assign num_out = (num_in >= NUM_OVER || num_prod > 37'hFFFF_FFFF) ? NUM_OVER
                   : num_prod[32:0];

  // checks made when the path ends
  always_comb begin
    logic [1:0] need;
    need = (cat_r == irlp_pkg::CAT_CHAR) ? 2'b01 : 2'b10;
    fin_path_bad = (digits_r != 2'b11) || (id_r == '0) || id_r[32]
                   || (size_r == '0) || size_r[32]
                   || ((ext_pos_r != 3'd0)
                       && ((ext_pos_r != 3'd3) || ((ext_m_r & need) == 2'b00)));
  end

  // per-byte parser update
  always_comb begin
    logic [3:0] p;
    logic       pre;
    irlp_pkg::phase_t ph;
    p = lit_pos_r;
    ph_nxt = ph_r; lit_pos_nxt = lit_pos_r; cand_nxt = cand_r; rej_nxt = rej_r;
    id_nxt = id_r; size_nxt = size_r; digits_nxt = digits_r;
    ext_pos_nxt = ext_pos_r; ext_m_nxt = ext_m_r; cat_nxt = cat_r;
    query_cnt_nxt = query_cnt_r;
    cand_tmp = cand_r; mask_len_ok = 1'b0;
    line_cnt_nxt = (line_cnt_r < irlp_pkg::COUNT_MAX) ? line_cnt_r + 13'd1 : line_cnt_r;
    // leading whitespace phases fall through into the token with position 0
    pre = 1'b0;
    ph = ph_r;
    if (ph_r == irlp_pkg::PH_PRE_METHOD && !ws) begin
      ph = irlp_pkg::PH_METHOD; p = 4'd0; pre = 1'b1;
    end else if (ph_r == irlp_pkg::PH_PRE_VERSION && !ws) begin
      ph = irlp_pkg::PH_VERSION; p = 4'd0; pre = 1'b1;
    end
    if (pre) begin
      ph_nxt = ph; lit_pos_nxt = 4'd0;
    end
    case (ph)
      irlp_pkg::PH_PRE_METHOD, irlp_pkg::PH_PRE_VERSION: begin
      end
      irlp_pkg::PH_METHOD: begin
        if (ws) begin
          if (p != 4'd3) rej_nxt = 1'b1;
          ph_nxt = irlp_pkg::PH_PRE_TARGET;
        end else begin
          if (p >= 4'd3) rej_nxt = 1'b1;
          else if (c != ((p == 4'd0) ? "G" : (p == 4'd1) ? "E" : "T")) rej_nxt = 1'b1;
          if (p < 4'd15) lit_pos_nxt = p + 4'd1;
        end
      end
      irlp_pkg::PH_PRE_TARGET: begin
        if (!ws) begin
          if (c != "/") rej_nxt = 1'b1;
          ph_nxt = irlp_pkg::PH_CATEGORY;
          lit_pos_nxt = 4'd0;
          cand_nxt = 5'h1F;
        end
      end
      irlp_pkg::PH_CATEGORY: begin
        if (c == "/") begin
          for (int i = 0; i < 5; i++)
            if (irlp_pkg::cat_len(3'(i)) != p) cand_tmp[i] = 1'b0;
          cand_nxt = cand_tmp;
          if (cand_tmp == 5'd0) rej_nxt = 1'b1;
          for (int i = 4; i >= 0; i--)
            if (cand_tmp[i]) cat_nxt = 3'(i);
          mask_len_ok = 1'b1;
          ph_nxt = irlp_pkg::PH_ID;
        end else if (ws || c == "?" || c == "#") begin
          rej_nxt = 1'b1;
          if (ws) ph_nxt = irlp_pkg::PH_PRE_VERSION;
        end else begin
          for (int i = 0; i < 5; i++)
            if (p >= irlp_pkg::cat_len(3'(i)) || irlp_pkg::cat_char(3'(i), p) != c)
              cand_tmp[i] = 1'b0;
          cand_nxt = cand_tmp;
          if (p < 4'd15) lit_pos_nxt = p + 4'd1;
        end
      end
      irlp_pkg::PH_ID: begin
        if (is_dig) begin
          id_nxt = num_out; digits_nxt[0] = 1'b1;
        end else if (c == "_") begin
          ph_nxt = irlp_pkg::PH_SIZE;
        end else begin
          rej_nxt = 1'b1;
          if (ws) ph_nxt = irlp_pkg::PH_PRE_VERSION;
        end
      end
      irlp_pkg::PH_SIZE: begin
        if (is_dig) begin
          size_nxt = num_out; digits_nxt[1] = 1'b1;
        end else if (c == ".") begin
          ph_nxt = irlp_pkg::PH_EXT; ext_pos_nxt = 3'd0; ext_m_nxt = 2'b11;
        end else if (c == "?") begin
          if (fin_path_bad) rej_nxt = 1'b1;
          ph_nxt = irlp_pkg::PH_QUERY;
        end else if (ws) begin
          if (fin_path_bad || query_cnt_r > {1'b0, max_query_r}) rej_nxt = 1'b1;
          ph_nxt = irlp_pkg::PH_PRE_VERSION;
        end else begin
          rej_nxt = 1'b1;
        end
      end
      irlp_pkg::PH_EXT: begin
        if (c == "?") begin
          if (fin_path_bad) rej_nxt = 1'b1;
          ph_nxt = irlp_pkg::PH_QUERY;
        end else if (ws) begin
          if (fin_path_bad || query_cnt_r > {1'b0, max_query_r}) rej_nxt = 1'b1;
          ph_nxt = irlp_pkg::PH_PRE_VERSION;
        end else if (c == "_" || c == "/" || c == "." || c == "#") begin
          rej_nxt = 1'b1;
        end else begin
          if (ext_pos_r >= 3'd3 || c != ((ext_pos_r == 3'd0) ? "j"
              : (ext_pos_r == 3'd1) ? "p" : "g")) ext_m_nxt[0] = 1'b0;
          if (ext_pos_r >= 3'd3 || c != ((ext_pos_r == 3'd0) ? "p"
              : (ext_pos_r == 3'd1) ? "n" : "g")) ext_m_nxt[1] = 1'b0;
          if (ext_pos_r < 3'd7) ext_pos_nxt = ext_pos_r + 3'd1;
        end
      end
      irlp_pkg::PH_QUERY: begin
        if (ws) begin
          if (query_cnt_r > {1'b0, max_query_r}) rej_nxt = 1'b1;
          ph_nxt = irlp_pkg::PH_PRE_VERSION;
        end else begin
          if (c == "#") rej_nxt = 1'b1;
          if (query_cnt_r < irlp_pkg::COUNT_MAX) query_cnt_nxt = query_cnt_r + 13'd1;
        end
      end
      irlp_pkg::PH_VERSION: begin
        if (ws) begin
          if (p != 4'd8) rej_nxt = 1'b1;
          ph_nxt = irlp_pkg::PH_POST;
        end else begin
          case (p)
            4'd0: if (c != "H") rej_nxt = 1'b1;
            4'd1: if (c != "T") rej_nxt = 1'b1;
            4'd2: if (c != "T") rej_nxt = 1'b1;
            4'd3: if (c != "P") rej_nxt = 1'b1;
            4'd4: if (c != "/") rej_nxt = 1'b1;
            4'd5: if (c != "1") rej_nxt = 1'b1;
            4'd6: if (c != ".") rej_nxt = 1'b1;
            4'd7: if (c != "0" && c != "1") rej_nxt = 1'b1;
            default: rej_nxt = 1'b1;
          endcase
          if (p < 4'd15) lit_pos_nxt = p + 4'd1;
        end
      end
      default: begin
        if (!ws) rej_nxt = 1'b1;
      end
    endcase
  end

  // verdict for the last byte
  assign ok = !rej_nxt && (line_cnt_nxt <= {1'b0, max_line_r})
              && (ph_nxt == irlp_pkg::PH_POST
                  || (ph_nxt == irlp_pkg::PH_VERSION && lit_pos_nxt == 4'd8));

  // state, limits and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_line_r <= 12'd2048;
      max_query_r <= 12'd512;
      ph_r <= irlp_pkg::PH_PRE_METHOD;
      line_cnt_r <= '0; query_cnt_r <= '0; lit_pos_r <= '0; cand_r <= 5'h1F;
      rej_r <= 1'b0; id_r <= '0; size_r <= '0; digits_r <= '0;
      ext_pos_r <= '0; ext_m_r <= 2'b11; cat_r <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == irlp_pkg::REG_MAX_LINE) max_line_r <= cfg_data;
        else max_query_r <= cfg_data;
      end
      if (out_valid && out_ready && !(take && in_line_end)) out_valid <= 1'b0;
      if (take) begin
        if (in_line_end) begin
          ph_r <= irlp_pkg::PH_PRE_METHOD;
          line_cnt_r <= '0; query_cnt_r <= '0; lit_pos_r <= '0; cand_r <= 5'h1F;
          rej_r <= 1'b0; id_r <= '0; size_r <= '0; digits_r <= '0;
          ext_pos_r <= '0; ext_m_r <= 2'b11; cat_r <= '0;
          out_valid <= 1'b1;
          out_accepted <= ok;
          out_category_code <= ok ? cat_nxt : 3'd0;
          out_image_id <= ok ? id_nxt[31:0] : 32'd0;
          out_image_size <= ok ? size_nxt[31:0] : 32'd0;
        end else begin
          ph_r <= ph_nxt; line_cnt_r <= line_cnt_nxt; query_cnt_r <= query_cnt_nxt;
          lit_pos_r <= lit_pos_nxt; cand_r <= cand_nxt; rej_r <= rej_nxt;
          id_r <= id_nxt; size_r <= size_nxt; digits_r <= digits_nxt;
          ext_pos_r <= ext_pos_nxt; ext_m_r <= ext_m_nxt;
          cat_r <= mask_len_ok ? cat_nxt : cat_r;
        end
      end
    end
  end

endmodule
`default_nettype wire

@@ rtl/irlp_checker.sv @@
`default_nettype none
`include "image_request_line_parser_defines.svh"
module irlp_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_line_end,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_accepted,
  input wire logic [2:0]  out_category_code,
  input wire logic [31:0] out_image_id,
  input wire logic [31:0] out_image_size
);

  // a rejected line carries zeros
  `IRLP_ASSERT(a_rej_zero, out_valid && !out_accepted |-> out_category_code == 3'd0 && out_image_id == 32'd0 && out_image_size == 32'd0, "rejected item not zero")
  // an accepted line has valid code and nonzero numbers
  `IRLP_ASSERT(a_acc_fields, out_valid && out_accepted |-> out_category_code <= 3'd4 && out_image_id != 32'd0 && out_image_size != 32'd0, "accepted item fields out of range")
  // a last byte taken gives a result next cycle
  `IRLP_ASSERT(a_result_follows, in_valid && in_ready && in_line_end |=> out_valid, "no result after last byte")
  // a result only appears after a last byte
  `IRLP_ASSERT(a_no_invent, $rose(out_valid) |-> $past(in_valid && in_ready && in_line_end), "result without last byte")
  // the input is never blocked while no result waits
  `IRLP_ASSERT_ALWAYS(a_ready_free, !out_valid |-> in_ready, "input stalled without pending result")

endmodule

bind image_request_line_parser irlp_checker u_irlp_checker (.*);
`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps
`default_nettype none
module tb;

  localparam int CYCLE_LIMIT = 2000000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_line_byte = '0;
  logic        in_line_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_accepted;
  logic [2:0]  out_category_code;
  logic [31:0] out_image_id;
  logic [31:0] out_image_size;
  logic        cfg_we = 1'b0;
  logic        cfg_index = irlp_pkg::REG_MAX_LINE;
  logic [11:0] cfg_data = '0;

  image_request_line_parser i_dut (
    .clk, .rst_n, .in_valid, .in_ready, .in_line_byte, .in_line_end,
    .out_valid, .out_ready, .out_accepted, .out_category_code,
    .out_image_id, .out_image_size, .cfg_we, .cfg_index, .cfg_data
  );

  always #4 clk = ~clk;

  typedef struct packed {
    logic        accepted;
    logic [2:0]  category;
    logic [31:0] image_id;
    logic [31:0] image_size;
  } verdict_t;

  verdict_t verdict_q[$];

  // predictor state
  logic [11:0] lim_line, lim_query;
  irlp_pkg::phase_t ph;
  logic [12:0] n_line, n_query;
  logic [3:0]  lit_pos;
  logic [4:0]  cand;
  logic        bad;
  logic [32:0] id_acc, size_acc;
  logic [1:0]  digits;
  logic [2:0]  ext_pos;
  logic [1:0]  ext_ok;
  logic [2:0]  cat_found;

  int sender_idle_pct, receiver_stall_pct;
  int errors, verdicts_seen, accepts_seen, bytes_sent, cycles;

  function automatic string cat_name(int i);
    case (i)
      0: return "Alliance";
      1: return "Corporation";
      2: return "Character";
      3: return "InventoryType";
      default: return "Render";
    endcase
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0d);
  endfunction

  function automatic logic [32:0] push_digit(logic [32:0] v, logic [7:0] c);
    logic [35:0] n;
    if (v[32]) return 33'h1_0000_0000;
    n = v * 10 + (c - "0");
    return (n > 36'hffff_ffff) ? 33'h1_0000_0000 : n[32:0];
  endfunction

  function automatic bit num_good(logic [32:0] v);
    return v != 0 && !v[32];
  endfunction

  task automatic clear_line_state();
    ph = irlp_pkg::PH_PRE_METHOD; n_line = 0; n_query = 0; lit_pos = 0; cand = 5'h1f;
    bad = 0; id_acc = 0; size_acc = 0; digits = 0; ext_pos = 0; ext_ok = 2'b11;
    cat_found = 0;
  endtask

  task automatic close_path();
    logic [1:0] need;
    need = (cat_found == irlp_pkg::CAT_CHAR) ? 2'b01 : 2'b10;
    if (digits != 2'b11 || !num_good(id_acc) || !num_good(size_acc)) bad = 1;
    if (ext_pos != 0 && (ext_pos != 3 || (ext_ok & need) == 0)) bad = 1;
  endtask

  task automatic close_target();
    if (n_query > {1'b0, lim_query}) bad = 1;
    ph = irlp_pkg::PH_PRE_VERSION;
  endtask

  // one byte through the line grammar
  task automatic parse_byte(logic [7:0] c);
    bit ws;
    string s;
    ws = is_space(c);
    if (ph == irlp_pkg::PH_PRE_METHOD && !ws) begin
      ph = irlp_pkg::PH_METHOD; lit_pos = 0;
    end
    if (ph == irlp_pkg::PH_PRE_VERSION && !ws) begin
      ph = irlp_pkg::PH_VERSION; lit_pos = 0;
    end
    case (ph)
      irlp_pkg::PH_PRE_METHOD, irlp_pkg::PH_PRE_VERSION: ;
      irlp_pkg::PH_METHOD: begin
        if (ws) begin
          if (lit_pos != 3) bad = 1;
          ph = irlp_pkg::PH_PRE_TARGET;
        end else begin
          s = "GET";
          if (lit_pos >= 3 || s[lit_pos] != c) bad = 1;
          if (lit_pos < 15) lit_pos++;
        end
      end
      irlp_pkg::PH_PRE_TARGET: begin
        if (!ws) begin
          if (c != "/") bad = 1;
          ph = irlp_pkg::PH_CATEGORY; lit_pos = 0; cand = 5'h1f;
        end
      end
      irlp_pkg::PH_CATEGORY: begin
        if (c == "/") begin
          for (int i = 0; i < 5; i++)
            if (cat_name(i).len() != lit_pos) cand[i] = 0;
          if (cand == 0) bad = 1;
          for (int i = 4; i >= 0; i--)
            if (cand[i]) cat_found = 3'(i);
          ph = irlp_pkg::PH_ID;
        end else if (ws || c == "?" || c == "#") begin
          bad = 1;
          if (ws) ph = irlp_pkg::PH_PRE_VERSION;
        end else begin
          for (int i = 0; i < 5; i++) begin
            s = cat_name(i);
            if (lit_pos >= s.len() || s[lit_pos] != c) cand[i] = 0;
          end
          if (lit_pos < 15) lit_pos++;
        end
      end
      irlp_pkg::PH_ID: begin
        if (c >= "0" && c <= "9") begin
          id_acc = push_digit(id_acc, c); digits[0] = 1;
        end else if (c == "_") begin
          ph = irlp_pkg::PH_SIZE;
        end else begin
          bad = 1;
          if (ws) ph = irlp_pkg::PH_PRE_VERSION;
        end
      end
      irlp_pkg::PH_SIZE: begin
        if (c >= "0" && c <= "9") begin
          size_acc = push_digit(size_acc, c); digits[1] = 1;
        end else if (c == ".") begin
          ph = irlp_pkg::PH_EXT; ext_pos = 0; ext_ok = 2'b11;
        end else if (c == "?") begin
          close_path(); ph = irlp_pkg::PH_QUERY;
        end else if (ws) begin
          close_path(); close_target();
        end else bad = 1;
      end
      irlp_pkg::PH_EXT: begin
        if (c == "?") begin
          close_path(); ph = irlp_pkg::PH_QUERY;
        end else if (ws) begin
          close_path(); close_target();
        end else if (c == "_" || c == "/" || c == "." || c == "#") begin
          bad = 1;
        end else begin
          s = "jpg";
          if (ext_pos >= 3 || s[ext_pos] != c) ext_ok[0] = 0;
          s = "png";
          if (ext_pos >= 3 || s[ext_pos] != c) ext_ok[1] = 0;
          if (ext_pos < 7) ext_pos++;
        end
      end
      irlp_pkg::PH_QUERY: begin
        if (ws) close_target();
        else begin
          if (c == "#") bad = 1;
          if (n_query < irlp_pkg::COUNT_MAX) n_query++;
        end
      end
      irlp_pkg::PH_VERSION: begin
        if (ws) begin
          if (lit_pos != 8) bad = 1;
          ph = irlp_pkg::PH_POST;
        end else begin
          s = "HTTP/1.";
          if (lit_pos < 7) begin
            if (s[lit_pos] != c) bad = 1;
          end else if (lit_pos == 7) begin
            if (c != "0" && c != "1") bad = 1;
          end else bad = 1;
          if (lit_pos < 15) lit_pos++;
        end
      end
      default: if (!ws) bad = 1;
    endcase
  endtask

  // accepted byte: update state and queue the verdict on the last byte
  task automatic predict_byte(logic [7:0] c, logic last);
    bit ok;
    verdict_t v;
    if (n_line < irlp_pkg::COUNT_MAX) n_line++;
    parse_byte(c);
    if (!last) return;
    ok = !bad && n_line <= {1'b0, lim_line} &&
         (ph == irlp_pkg::PH_POST || (ph == irlp_pkg::PH_VERSION && lit_pos == 8));
    v.accepted = ok;
    v.category = ok ? cat_found : 3'd0;
    v.image_id = ok ? id_acc[31:0] : 32'd0;
    v.image_size = ok ? size_acc[31:0] : 32'd0;
    verdict_q.push_back(v);
    clear_line_state();
  endtask

  // valid stays high after an accept until the next byte or an idle cycle
  task automatic send_byte(logic [7:0] c, logic last);
    while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_line_byte <= c;
    in_line_end <= last;
    do @(posedge clk); while (!in_ready);
    predict_byte(c, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_line(string s);
    if (s.len() == 0) s = " ";
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(logic idx, logic [11:0] val);
    wait_drained();
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == irlp_pkg::REG_MAX_LINE) lim_line = val; else lim_query = val;
  endtask

  function automatic string rand_digits(int n);
    string s;
    s = "";
    for (int i = 0; i < n; i++) s = {s, string'(byte'("0" + $urandom_range(9)))};
    return s;
  endfunction

  function automatic string rand_space();
    case ($urandom_range(7))
      0: return "\t";
      1: return "\n";
      2: return "\r";
      3: return {" ", string'(byte'(8'h0b))};
      4: return string'(byte'(8'h0c));
      default: return " ";
    endcase
  endfunction

  // mostly well-formed requests with random content, some mutated
  function automatic string rand_request();
    string s, ext, q;
    int cat, k;
    cat = $urandom_range(4);
    case ($urandom_range(9))
      0: ext = "";
      1: ext = ".jpg";
      2: ext = ".png";
      3: ext = ".gif";
      4: ext = ".jp";
      default: ext = (cat == 2) ? ".jpg" : ".png";
    endcase
    q = "";
    if ($urandom_range(3) == 0) begin
      q = "?";
      k = $urandom_range(12);
      for (int i = 0; i < k; i++) q = {q, string'(byte'($urandom_range(33, 126)))};
    end
    case ($urandom_range(9))
      0: s = rand_digits($urandom_range(9, 12));
      default: s = rand_digits($urandom_range(1, 5));
    endcase
    s = {"GET", rand_space(), "/", cat_name(cat), "/", s, "_",
         rand_digits($urandom_range(1, 5)), ext, q, rand_space(),
         $urandom_range(1) ? "HTTP/1.1" : "HTTP/1.0"};
    if ($urandom_range(3) == 0) s = {rand_space(), s, rand_space()};
    // corrupt a few
    if ($urandom_range(4) == 0) begin
      k = $urandom_range(s.len() - 1);
      s[k] = byte'($urandom_range(255));
    end
    return s;
  endfunction

  function automatic string rand_noise();
    string s;
    int n;
    s = "";
    n = $urandom_range(1, 20);
    for (int i = 0; i < n; i++) s = {s, string'(byte'($urandom_range(1, 255)))};
    return s;
  endfunction

  // directed table
  typedef struct {
    string    line;
    bit       known;
    verdict_t want;
  } case_t;

  case_t directed[] = '{
    '{"GET /Alliance/1_1 HTTP/1.0", 1, '{1'b1, 3'd0, 32'd1, 32'd1}},
    '{"GET /Corporation/42_128.png HTTP/1.1", 1, '{1'b1, 3'd1, 32'd42, 32'd128}},
    '{"GET /Character/90_256.jpg HTTP/1.1", 1, '{1'b1, 3'd2, 32'd90, 32'd256}},
    '{"GET /InventoryType/7_32.png?a=b HTTP/1.0", 1,
      '{1'b1, 3'd3, 32'd7, 32'd32}},
    '{"GET /Render/4294967295_0004294967295 HTTP/1.1", 1,
      '{1'b1, 3'd4, 32'hffff_ffff, 32'hffff_ffff}},
    '{"GET /Render/4294967296_1 HTTP/1.1", 1, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{"GET /Render/0_1 HTTP/1.1", 1, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{"GET /Character/1_1.png HTTP/1.1", 1, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{"GET /Alliance/1_1.jpg HTTP/1.1", 1, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{"GET /Alliance/1_1#x HTTP/1.1", 1, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{"GET /Alliance/1_1?x#y HTTP/1.1", 1, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{"GET /Alliance/1.2_1 HTTP/1.1", 1, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{"GET /Alliance/1_2_3 HTTP/1.1", 1, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{"GET /Alliance/1_2/3 HTTP/1.1", 1, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{"GET /Alliance/1_2.p.ng HTTP/1.1", 1, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{"GET /Alliances/1_2 HTTP/1.1", 1, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{"POST /Alliance/1_2 HTTP/1.1", 1, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{"GET /Alliance/1_2 HTTP/1.2", 1, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{"GET /Alliance/1_2", 1, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{"GET /Alliance/1_2 HTTP/1.1 x", 1, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{"\t GET\v/Render/5_6?q??\fHTTP/1.0 \r\n", 0, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{"GET /Alliance/_2 HTTP/1.1", 1, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{"\xff", 1, '{1'b0, 3'd0, 32'd0, 32'd0}},
    '{"GET /Render/3_4? HTTP/1.1", 0, '{1'b0, 3'd0, 32'd0, 32'd0}}
  };

  // result checking
  always @(posedge clk) begin
    verdict_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_accepted, out_category_code, out_image_id, out_image_size};
      verdicts_seen++;
      if (got.accepted) accepts_seen++;
      if (verdict_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item %p", got);
      end else begin
        want = verdict_q.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk)
    out_ready <= !(receiver_stall_pct != 0 && $urandom_range(99) < receiver_stall_pct);

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL image_request_line_parser");
      $finish;
    end
  end

  initial begin
    verdict_t v;
    int base;
    lim_line = 12'd2048; lim_query = 12'd512;
    clear_line_state();
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed table at reset limits
    foreach (directed[i]) begin
      send_line(directed[i].line);
      if (directed[i].known) begin
        v = verdict_q[$];
        if (v !== directed[i].want) begin
          errors++;
          if (errors <= 10)
            $display("row %0d: table says %p, predictor %p", i, directed[i].want, v);
        end
      end
    end

    // limit extremes
    write_limit(irlp_pkg::REG_MAX_LINE, 12'd26);
    write_limit(irlp_pkg::REG_MAX_QUERY, 12'd0);
    send_line("GET /Alliance/1_1 HTTP/1.0");
    send_line("GET /Alliance/1_1  HTTP/1.0");
    send_line("GET /Alliance/1_1? HTTP/1.0");
    send_line("GET /Alliance/1_1?a HTTP/1.0");
    write_limit(irlp_pkg::REG_MAX_LINE, 12'd0);
    send_line("GET /Alliance/1_1 HTTP/1.0");
    write_limit(irlp_pkg::REG_MAX_LINE, 12'd4095);
    write_limit(irlp_pkg::REG_MAX_QUERY, 12'd4095);
    send_line("GET /Render/1_1?aaaa HTTP/1.1");

    // random phases over idling patterns and limit settings
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 86; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 86; end
        default: begin sender_idle_pct = 12; receiver_stall_pct = 12; end
      endcase
      write_limit(irlp_pkg::REG_MAX_LINE, $urandom_range(3) == 0 ?
                  12'($urandom_range(20, 45)) : 12'($urandom_range(46, 4095)));
      write_limit(irlp_pkg::REG_MAX_QUERY, $urandom_range(1) ?
                  12'($urandom_range(0, 8)) : 12'($urandom_range(9, 4095)));
      base = bytes_sent;
      while (bytes_sent < base + 30)
        send_line($urandom_range(7) == 0 ? rand_noise() : rand_request());
      if (phase == 1) wait_drained();
    end

    wait_drained();
    repeat (20) @(negedge clk);
    $display("sent %0d bytes; %0d verdicts checked, %0d of them accepted",
             bytes_sent, verdicts_seen, accepts_seen);
    $display("limits swept from zero to 4095, idling and stalls varied by phase");
    if (errors == 0 && verdict_q.size() == 0) begin
      $display("PASS image_request_line_parser");
    end else begin
      $display("%0d failures, %0d verdicts outstanding", errors, verdict_q.size());
      $display("FAIL image_request_line_parser");
    end
    $finish;
  end

endmodule
`default_nettype wire
